FILE: src/ncg_pkg.sv
// Shared types, constants and the microcode program of the next-combination generator.
package ncg_pkg;

    localparam int MAX_CHOOSE = 8;
    localparam int VALUE_BITS = 8;

    // Field widths of the configuration registers and the result item.
    localparam int SIZE_W  = 9;
    localparam int COUNT_W = 4;
    localparam int EV_W    = 8;
    localparam int POS_W   = 3;

    localparam int PTR_W  = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;
    localparam int N_W    = VALUE_BITS + 1;
    localparam int CMP_W  = (N_W > SIZE_W) ? N_W : SIZE_W;
    localparam int TOP_W  = ((CMP_W > COUNT_W) ? CMP_W : COUNT_W) + 1;

    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    typedef enum logic [1:0] {
        REG_SET_SIZE     = 2'd0,
        REG_CHOOSE_COUNT = 2'd1,
        REG_DISTINCT     = 2'd2,
        REG_CLEAR_ON_END = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [SIZE_W-1:0]  set_size;
        logic [COUNT_W-1:0] choose_count;
        logic               distinct_mode;
        logic               clear_on_end;
    } t_cfg;

    typedef enum logic [3:0] {
        STEP_IDLE       = 4'd0,
        STEP_CHECK      = 4'd1,
        STEP_BRANCH     = 4'd2,
        STEP_INIT       = 4'd3,
        STEP_SCAN       = 4'd4,
        STEP_SCAN_DEC   = 4'd5,
        STEP_INC        = 4'd6,
        STEP_FILL       = 4'd7,
        STEP_EMIT_START = 4'd8,
        STEP_EMIT       = 4'd9,
        STEP_EXHAUST    = 4'd10
    } t_step;

    typedef enum logic [3:0] {
        ACT_NOP      = 4'd0,
        ACT_ACCEPT   = 4'd1,
        ACT_PTR_LAST = 4'd2,
        ACT_INIT_WR  = 4'd3,
        ACT_PTR_DEC  = 4'd4,
        ACT_INC      = 4'd5,
        ACT_FILL     = 4'd6,
        ACT_PTR_CLR  = 4'd7,
        ACT_EMIT     = 4'd8,
        ACT_EXHAUST  = 4'd9
    } t_act;

    typedef enum logic [3:0] {
        COND_ALWAYS    = 4'd0,
        COND_IN_VALID  = 4'd1,
        COND_BAD       = 4'd2,
        COND_HOLDING   = 4'd3,
        COND_BELOW     = 4'd4,
        COND_PTR_ZERO  = 4'd5,
        COND_PTR_LAST  = 4'd6,
        COND_OUT_FREE  = 4'd7,
        COND_EMIT_DONE = 4'd8
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_step jump_true;
        t_step jump_false;
    } t_uword;

    // Sequencer to datapath.
    typedef struct packed {
        t_step step;
        t_act  act;
    } t_ctrl;

    // Datapath to sequencer.
    typedef struct packed {
        logic in_valid;
        logic bad;
        logic holding;
        logic below;
        logic ptr_zero;
        logic ptr_last;
        logic out_free;
    } t_flags;

    function automatic t_uword ucode_rom(input t_step step);
        t_uword w;
        unique case (step)
            STEP_IDLE:       w = '{ACT_ACCEPT,   COND_IN_VALID,  STEP_CHECK,      STEP_IDLE};
            STEP_CHECK:      w = '{ACT_PTR_LAST, COND_BAD,       STEP_EXHAUST,    STEP_BRANCH};
            STEP_BRANCH:     w = '{ACT_NOP,      COND_HOLDING,   STEP_SCAN,       STEP_INIT};
            STEP_INIT:       w = '{ACT_INIT_WR,  COND_PTR_ZERO,  STEP_EMIT_START, STEP_INIT};
            STEP_SCAN:       w = '{ACT_NOP,      COND_BELOW,     STEP_INC,        STEP_SCAN_DEC};
            STEP_SCAN_DEC:   w = '{ACT_PTR_DEC,  COND_PTR_ZERO,  STEP_EXHAUST,    STEP_SCAN};
            STEP_INC:        w = '{ACT_INC,      COND_PTR_LAST,  STEP_EMIT_START, STEP_FILL};
            STEP_FILL:       w = '{ACT_FILL,     COND_PTR_LAST,  STEP_EMIT_START, STEP_FILL};
            STEP_EMIT_START: w = '{ACT_PTR_CLR,  COND_ALWAYS,    STEP_EMIT,       STEP_EMIT};
            STEP_EMIT:       w = '{ACT_EMIT,     COND_EMIT_DONE, STEP_IDLE,       STEP_EMIT};
            STEP_EXHAUST:    w = '{ACT_EXHAUST,  COND_OUT_FREE,  STEP_IDLE,       STEP_EXHAUST};
            default:         w = '{ACT_NOP,      COND_ALWAYS,    STEP_IDLE,       STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: src/ncg_if.sv
// Handshake interfaces of the request and result channels.
interface ncg_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface ncg_out_if;
    logic                    valid;
    logic                    ready;
    logic [ncg_pkg::EV_W-1:0]  element_value;
    logic [ncg_pkg::POS_W-1:0] position;
    logic                    found;
    logic                    last;

    modport source (output valid, output element_value, output position, output found,
                    output last, input ready);
    modport sink   (input valid, input element_value, input position, input found,
                    input last, output ready);
endinterface

FILE: src/ncg_cfg.sv
// APB register block holding the generator configuration.
module ncg_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ncg_pkg::APB_AW-1:0]  paddr,
    input  logic [ncg_pkg::APB_DW-1:0]  pwdata,
    output logic [ncg_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output ncg_pkg::t_cfg               o_cfg
);

    ncg_pkg::t_cfg    r_cfg;
    ncg_pkg::t_cfg    n_cfg;
    ncg_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = ncg_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                ncg_pkg::REG_SET_SIZE:
                    n_cfg.set_size = pwdata[ncg_pkg::SIZE_W-1:0];
                ncg_pkg::REG_CHOOSE_COUNT:
                    n_cfg.choose_count = pwdata[ncg_pkg::COUNT_W-1:0];
                ncg_pkg::REG_DISTINCT:
                    n_cfg.distinct_mode = pwdata[0];
                ncg_pkg::REG_CLEAR_ON_END:
                    n_cfg.clear_on_end = pwdata[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_size      <= ncg_pkg::SIZE_W'(8);
            r_cfg.choose_count  <= ncg_pkg::COUNT_W'(2);
            r_cfg.distinct_mode <= 1'b0;
            r_cfg.clear_on_end  <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            ncg_pkg::REG_SET_SIZE:     prdata = ncg_pkg::APB_DW'(r_cfg.set_size);
            ncg_pkg::REG_CHOOSE_COUNT: prdata = ncg_pkg::APB_DW'(r_cfg.choose_count);
            ncg_pkg::REG_DISTINCT:     prdata = ncg_pkg::APB_DW'(r_cfg.distinct_mode);
            ncg_pkg::REG_CLEAR_ON_END: prdata = ncg_pkg::APB_DW'(r_cfg.clear_on_end);
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/ncg_useq.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
module ncg_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ncg_pkg::t_flags i_flags,
    output ncg_pkg::t_ctrl  o_ctrl
);

    ncg_pkg::t_step  r_step;
    ncg_pkg::t_step  n_step;
    ncg_pkg::t_uword w_word;
    logic            w_taken;

    assign w_word = ncg_pkg::ucode_rom(r_step);

    always_comb begin
        unique case (w_word.cond)
            ncg_pkg::COND_ALWAYS:    w_taken = 1'b1;
            ncg_pkg::COND_IN_VALID:  w_taken = i_flags.in_valid;
            ncg_pkg::COND_BAD:       w_taken = i_flags.bad;
            ncg_pkg::COND_HOLDING:   w_taken = i_flags.holding;
            ncg_pkg::COND_BELOW:     w_taken = i_flags.below;
            ncg_pkg::COND_PTR_ZERO:  w_taken = i_flags.ptr_zero;
            ncg_pkg::COND_PTR_LAST:  w_taken = i_flags.ptr_last;
            ncg_pkg::COND_OUT_FREE:  w_taken = i_flags.out_free;
            ncg_pkg::COND_EMIT_DONE: w_taken = i_flags.out_free && i_flags.ptr_last;
            default:                 w_taken = 1'b1;
        endcase
        n_step = w_taken ? w_word.jump_true : w_word.jump_false;
    end

    always_comb begin
        o_ctrl.step = r_step;
        o_ctrl.act  = w_word.act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ncg_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

FILE: src/ncg_dpath.sv
// Datapath: selection registers, position pointer, carry value and result register.
module ncg_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ncg_pkg::t_cfg    i_cfg,
    input  ncg_pkg::t_ctrl   i_ctrl,
    output ncg_pkg::t_flags  o_flags,
    ncg_in_if.sink           i_in,
    ncg_out_if.source        o_out
);

    localparam logic [ncg_pkg::CMP_W-1:0] LIMIT =
        ncg_pkg::CMP_W'(1) << ncg_pkg::VALUE_BITS;

    logic [ncg_pkg::VALUE_BITS-1:0] r_sel [ncg_pkg::MAX_CHOOSE];
    logic [ncg_pkg::PTR_W-1:0]      r_ptr;
    logic [ncg_pkg::VALUE_BITS-1:0] r_carry;
    logic                           r_holding;

    logic                       r_out_valid;
    logic [ncg_pkg::EV_W-1:0]   r_out_value;
    logic [ncg_pkg::POS_W-1:0]  r_out_pos;
    logic                       r_out_found;
    logic                       r_out_last;

    logic [ncg_pkg::CMP_W-1:0]      w_size;
    logic [ncg_pkg::CMP_W-1:0]      w_n;
    logic [ncg_pkg::COUNT_W-1:0]    w_k;
    logic [ncg_pkg::PTR_W-1:0]      w_k_last;
    logic [ncg_pkg::TOP_W-1:0]      w_top;
    logic [ncg_pkg::VALUE_BITS-1:0] w_cur;
    logic [ncg_pkg::VALUE_BITS-1:0] w_wr_val;
    logic                           w_wr_en;
    logic                           w_out_free;
    logic                           w_accept;

    // Saturate the registers into the ranges the stepping logic expects.
    always_comb begin
        w_size = ncg_pkg::CMP_W'(i_cfg.set_size);
        w_n    = (w_size > LIMIT) ? LIMIT : w_size;
        if (i_cfg.choose_count == '0) begin
            w_k = ncg_pkg::COUNT_W'(1);
        end else if (i_cfg.choose_count > ncg_pkg::COUNT_W'(ncg_pkg::MAX_CHOOSE)) begin
            w_k = ncg_pkg::COUNT_W'(ncg_pkg::MAX_CHOOSE);
        end else begin
            w_k = i_cfg.choose_count;
        end
        w_k_last = ncg_pkg::PTR_W'(w_k - ncg_pkg::COUNT_W'(1));
    end

    assign w_cur = r_sel[r_ptr];

    // The largest value a position may hold; in distinct mode it is n - k + position.
    always_comb begin
        if (i_cfg.distinct_mode) begin
            w_top = ncg_pkg::TOP_W'(w_n) - ncg_pkg::TOP_W'(w_k) + ncg_pkg::TOP_W'(r_ptr);
        end else begin
            w_top = ncg_pkg::TOP_W'(w_n) - ncg_pkg::TOP_W'(1);
        end
    end

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_accept   = (i_ctrl.act == ncg_pkg::ACT_ACCEPT) && i_in.valid;

    always_comb begin
        o_flags.in_valid = i_in.valid;
        o_flags.bad      = (w_n == '0) ||
                           (i_cfg.distinct_mode && (ncg_pkg::CMP_W'(w_k) > w_n));
        o_flags.holding  = r_holding;
        o_flags.below    = ncg_pkg::TOP_W'(w_cur) < w_top;
        o_flags.ptr_zero = (r_ptr == '0);
        o_flags.ptr_last = (r_ptr == w_k_last);
        o_flags.out_free = w_out_free;
    end

    // At most one selection entry is written per cycle, at the pointer, on the init, increment and fill actions.
    always_comb begin
        w_wr_en  = 1'b0;
        w_wr_val = w_cur;
        unique case (i_ctrl.act)
            ncg_pkg::ACT_INIT_WR: begin
                w_wr_en  = 1'b1;
                w_wr_val = i_cfg.distinct_mode ? ncg_pkg::VALUE_BITS'(r_ptr) : '0;
            end
            ncg_pkg::ACT_INC: begin
                w_wr_en  = 1'b1;
                w_wr_val = w_cur + ncg_pkg::VALUE_BITS'(1);
            end
            ncg_pkg::ACT_FILL: begin
                w_wr_en  = 1'b1;
                w_wr_val = i_cfg.distinct_mode ? r_carry + ncg_pkg::VALUE_BITS'(1) : r_carry;
            end
            default: begin
                w_wr_en  = 1'b0;
                w_wr_val = w_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_sel[r_ptr] <= w_wr_val;
            r_carry      <= w_wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            unique case (i_ctrl.act)
                ncg_pkg::ACT_PTR_LAST: r_ptr <= w_k_last;
                ncg_pkg::ACT_PTR_CLR:  r_ptr <= '0;
                ncg_pkg::ACT_INIT_WR,
                ncg_pkg::ACT_PTR_DEC:  r_ptr <= r_ptr - ncg_pkg::PTR_W'(1);
                ncg_pkg::ACT_INC,
                ncg_pkg::ACT_FILL:     r_ptr <= r_ptr + ncg_pkg::PTR_W'(1);
                ncg_pkg::ACT_EMIT: begin
                    if (w_out_free) begin
                        r_ptr <= r_ptr + ncg_pkg::PTR_W'(1);
                    end
                end
                default:               r_ptr <= r_ptr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding <= 1'b0;
        end else if (w_accept && i_in.restart) begin
            r_holding <= 1'b0;
        end else if (i_ctrl.act == ncg_pkg::ACT_INIT_WR) begin
            r_holding <= 1'b1;
        end else if ((i_ctrl.act == ncg_pkg::ACT_EXHAUST) && w_out_free &&
                     i_cfg.clear_on_end) begin
            r_holding <= 1'b0;
        end
    end

    // Result register: a new result is loaded when the old one is gone or leaves now.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free && ((i_ctrl.act == ncg_pkg::ACT_EMIT) ||
                                    (i_ctrl.act == ncg_pkg::ACT_EXHAUST))) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && (i_ctrl.act == ncg_pkg::ACT_EMIT)) begin
            r_out_value <= ncg_pkg::EV_W'(w_cur);
            r_out_pos   <= ncg_pkg::POS_W'(r_ptr);
            r_out_found <= 1'b1;
            r_out_last  <= (r_ptr == w_k_last);
        end else if (w_out_free && (i_ctrl.act == ncg_pkg::ACT_EXHAUST)) begin
            r_out_value <= '0;
            r_out_pos   <= '0;
            r_out_found <= 1'b0;
            r_out_last  <= 1'b1;
        end
    end

    assign i_in.ready          = (i_ctrl.act == ncg_pkg::ACT_ACCEPT);
    assign o_out.valid         = r_out_valid;
    assign o_out.element_value = r_out_value;
    assign o_out.position      = r_out_pos;
    assign o_out.found         = r_out_found;
    assign o_out.last          = r_out_last;

endmodule

FILE: src/next_combination_generator.sv
// Top level of the lexicographic next-combination generator.
//
// Each transaction on the request channel i_in asks for the next k-selection of
// the values 0..n-1; restart set discards the stored selection and yields the
// first one. The answer comes on o_out as k transactions, one element each with
// its position, found set and last marking the final one. When the selections
// are used up, a single transaction with found clear and last set reports it.
// Registers set_size, choose_count, distinct_mode and clear_on_end sit on the
// APB port at byte addresses 0, 4, 8 and 12; write them only while idle.
// A request is taken only when the previous one has handed all its results to
// the output register. The microcode touches one selection entry per step: the
// scan spends two steps per position, the refill and the emission one step per
// position. When the receiver stalls, the result waits in the output register
// and the sequencer holds its step.
// Reset clears the sequencer, the output register and the stored-selection flag,
// so the first request after reset always yields the first selection.
module next_combination_generator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ncg_pkg::APB_AW-1:0]  paddr,
    input  logic [ncg_pkg::APB_DW-1:0]  pwdata,
    output logic [ncg_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    ncg_in_if.sink                      i_in,
    ncg_out_if.source                   o_out
);

    ncg_pkg::t_cfg   w_cfg;
    ncg_pkg::t_ctrl  w_ctrl;
    ncg_pkg::t_flags w_flags;

    ncg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ncg_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    ncg_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_ctrl  (w_ctrl),
        .o_flags (w_flags),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    // An accepted request always moves the sequencer to the range check.
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (w_ctrl.step == ncg_pkg::STEP_CHECK))
        else $error("request accepted but sequencer did not move to the check step");

    // An exhausted report is always the final result of its request.
    a_exhaust_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> o_out.last)
        else $error("exhausted report without last");

    // Elements of one selection follow each other without a gap.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.found && !o_out.last) |=> o_out.valid)
        else $error("gap inside a selection");

    // No new request is taken while a selection is still being emitted.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.step == ncg_pkg::STEP_EMIT) |-> !i_in.ready)
        else $error("request channel ready during emission");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for next_combination_generator: directed and random requests against a cycle-free predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SET_SIZE_CAP   = 1 << ncg_pkg::VALUE_BITS;

    typedef struct packed {
        logic [ncg_pkg::EV_W-1:0]  element_value;
        logic [ncg_pkg::POS_W-1:0] position;
        logic                      found;
        logic                      last;
    } t_element;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ncg_pkg::APB_AW-1:0] paddr;
    logic [ncg_pkg::APB_DW-1:0] pwdata;
    logic [ncg_pkg::APB_DW-1:0] prdata;
    logic                       pready;

    ncg_in_if  req_if ();
    ncg_out_if res_if ();

    next_combination_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: a private copy of the registers and of the stored selection.
    ncg_pkg::t_cfg            cfg_model;
    logic [ncg_pkg::EV_W-1:0] selection_model [ncg_pkg::MAX_CHOOSE];
    logic                     holding_model;

    logic     pending_restarts [$];
    t_element expected_elements [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int setting_count  = 0;
    int requests_sent  = 0;
    int requests_taken = 0;
    int elements_seen  = 0;
    int exhausted_seen = 0;
    int mismatches     = 0;
    int stall_cycles   = 0;

    task automatic predict_next_selection(input logic restart);
        int       n;
        int       k;
        int       j;
        int       top;
        bit       distinct;
        bit       exhausted;
        t_element item;
        n = cfg_model.set_size;
        if (n > SET_SIZE_CAP) n = SET_SIZE_CAP;
        k = cfg_model.choose_count;
        if (k < 1) k = 1;
        if (k > ncg_pkg::MAX_CHOOSE) k = ncg_pkg::MAX_CHOOSE;
        distinct = cfg_model.distinct_mode;
        if (restart) holding_model = 1'b0;
        exhausted = (n == 0) || (distinct && k > n);
        if (!exhausted && !holding_model) begin
            for (int i = 0; i < k; i++) begin
                selection_model[i] = distinct ? ncg_pkg::EV_W'(i) : '0;
            end
            holding_model = 1'b1;
        end else if (!exhausted) begin
            // Walk left past every position that already sits at or above its maximum.
            j = k;
            while (j > 0) begin
                top = distinct ? (n - k + j - 1) : (n - 1);
                if (int'(selection_model[j-1]) < top) break;
                j--;
            end
            if (j == 0) begin
                exhausted = 1'b1;
            end else begin
                selection_model[j-1] = selection_model[j-1] + 1'b1;
                for (int i = j; i < k; i++) begin
                    selection_model[i] = distinct ? selection_model[i-1] + 1'b1
                                                  : selection_model[i-1];
                end
            end
        end
        if (exhausted) begin
            item = '{element_value: '0, position: '0, found: 1'b0, last: 1'b1};
            expected_elements.insert(expected_elements.size(), item);
            if (cfg_model.clear_on_end) holding_model = 1'b0;
        end else begin
            for (int i = 0; i < k; i++) begin
                item.element_value = selection_model[i];
                item.position      = ncg_pkg::POS_W'(i);
                item.found         = 1'b1;
                item.last          = (i == k - 1);
                expected_elements.insert(expected_elements.size(), item);
            end
        end
    endtask

    // Request driver: a new request may be presented once the previous one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_next_selection(req_if.restart);
                requests_taken++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_restarts.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    req_if.valid   <= 1'b1;
                    req_if.restart <= pending_restarts.pop_front();
                    requests_sent++;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_element want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                elements_seen++;
                if (!res_if.found) exhausted_seen++;
                if (expected_elements.size() == 0) begin
                    $display("%0t: unexpected result value=%0d position=%0d found=%0b last=%0b",
                             $time, res_if.element_value, res_if.position, res_if.found,
                             res_if.last);
                    mismatches++;
                end else begin
                    want = expected_elements.pop_front();
                    if (res_if.element_value !== want.element_value) begin
                        $display("%0t: element_value expected %0d, got %0d",
                                 $time, want.element_value, res_if.element_value);
                        mismatches++;
                    end
                    if (res_if.position !== want.position) begin
                        $display("%0t: position expected %0d, got %0d",
                                 $time, want.position, res_if.position);
                        mismatches++;
                    end
                    if (res_if.found !== want.found) begin
                        $display("%0t: found expected %0b, got %0b",
                                 $time, want.found, res_if.found);
                        mismatches++;
                    end
                    if (res_if.last !== want.last) begin
                        $display("%0t: last expected %0b, got %0b",
                                 $time, want.last, res_if.last);
                        mismatches++;
                    end
                end
            end
            res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Ends the run when neither channel nor the register port has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (req_if.valid && req_if.ready)
                || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_register(input ncg_pkg::t_reg_idx idx,
                                  input logic [ncg_pkg::APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ncg_pkg::REG_SET_SIZE:
                cfg_model.set_size      = value[ncg_pkg::SIZE_W-1:0];
            ncg_pkg::REG_CHOOSE_COUNT:
                cfg_model.choose_count  = value[ncg_pkg::COUNT_W-1:0];
            ncg_pkg::REG_DISTINCT:
                cfg_model.distinct_mode = value[0];
            ncg_pkg::REG_CLEAR_ON_END:
                cfg_model.clear_on_end  = value[0];
            default: ;
        endcase
    endtask

    // Every sent request must be taken and all of its results checked.
    task automatic wait_until_drained();
        while (pending_restarts.size() != 0 || requests_sent != requests_taken
               || expected_elements.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic configure(input int n, input int k, input bit distinct, input bit clear);
        wait_until_drained();
        repeat (4) @(posedge i_clk);
        write_register(ncg_pkg::REG_SET_SIZE, ncg_pkg::APB_DW'(n));
        write_register(ncg_pkg::REG_CHOOSE_COUNT, ncg_pkg::APB_DW'(k));
        write_register(ncg_pkg::REG_DISTINCT, ncg_pkg::APB_DW'(distinct));
        write_register(ncg_pkg::REG_CLEAR_ON_END, ncg_pkg::APB_DW'(clear));
        setting_count++;
        // Rotate through the idling modes so consecutive settings see different patterns.
        case (setting_count % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
            default: begin src_idle_pct = 13; sink_stall_pct = 13; end
        endcase
    endtask

    task automatic queue_requests(input int count, input bit first_restart);
        for (int i = 0; i < count; i++) begin
            pending_restarts.insert(pending_restarts.size(), (i == 0) ? first_restart : 1'b0);
        end
    endtask

    initial begin
        int random_requests;
        int n;
        int k;
        int pick;
        int count;
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_if.valid   = 1'b0;
        req_if.restart = 1'b0;
        res_if.ready   = 1'b0;
        cfg_model      = '{set_size: 9'd8, choose_count: 4'd2, distinct_mode: 1'b0,
                           clear_on_end: 1'b1};
        holding_model  = 1'b0;
        for (int i = 0; i < ncg_pkg::MAX_CHOOSE; i++) selection_model[i] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Values after reset: the first request always yields the first selection.
        queue_requests(3, 1'b0);
        // The widest selection early on, so every stored entry is written before any read.
        configure(8, 8, 1'b0, 1'b1);
        queue_requests(2, 1'b1);
        // A single value: stored entries above the maximum count as saturated.
        configure(1, 8, 1'b0, 1'b1);
        queue_requests(3, 1'b0);
        configure(3, 3, 1'b0, 1'b1);
        queue_requests(3, 1'b1);
        // Shrinking the set leaves the last entry above its maximum; the middle position steps.
        configure(2, 3, 1'b0, 1'b1);
        queue_requests(3, 1'b0);
        // Exhaustion with the selection kept reports again on the next request.
        configure(8, 8, 1'b1, 1'b0);
        queue_requests(3, 1'b1);
        // More elements than values in distinct mode, with and without restart.
        configure(3, 4, 1'b1, 1'b1);
        queue_requests(1, 1'b0);
        queue_requests(1, 1'b1);
        configure(0, 2, 1'b0, 1'b1);
        queue_requests(1, 1'b0);
        // Register values beyond the supported range saturate.
        configure(511, 15, 1'b0, 1'b1);
        queue_requests(2, 1'b1);
        configure(2, 0, 1'b0, 1'b1);
        queue_requests(2, 1'b0);

        random_requests = 0;
        while (random_requests < 150) begin
            pick = $urandom_range(99);
            if (pick < 8) n = 0;
            else if (pick < 16) n = $urandom_range(511, 257);
            else if (pick < 26) n = SET_SIZE_CAP;
            else n = $urandom_range(12, 1);
            pick = $urandom_range(99);
            if (pick < 8) k = 0;
            else if (pick < 16) k = $urandom_range(15, 9);
            else k = $urandom_range(ncg_pkg::MAX_CHOOSE, 1);
            configure(n, k, 1'($urandom_range(1)), 1'($urandom_range(1)));
            count = $urandom_range(24, 8);
            for (int i = 0; i < count; i++) begin
                pending_restarts.insert(pending_restarts.size(), $urandom_range(99) < 8);
            end
            random_requests += count;
        end

        // One long walk over a single position reaches every element value and wraps.
        configure(300, 1, 1'b0, 1'b1);
        queue_requests(258, 1'b1);

        wait_until_drained();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d requests over %0d register settings and four idling modes.",
                 requests_taken, setting_count + 1);
        $display("Checked %0d results, %0d of them exhaustion reports; %0d mismatches.",
                 elements_seen, exhausted_seen, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
